/* design/rhhs_pkg.sv */
// Shared types and constants of the Robin Hood hash set.
package rhhs_pkg;

  // Request item and result item
  typedef struct packed {
    logic [1:0]  req_type;
    logic [30:0] lookup_key;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [9:0]  probe_distance;
    logic [10:0] element_count;
    logic [9:0]  max_probe_distance;
  } res_t;

  // Request type codes
  localparam logic [1:0] REQ_LOOKUP = 2'd0;
  localparam logic [1:0] REQ_INSERT = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;

  // Operation class handed from front to back
  localparam logic [1:0] OP_LOOKUP  = 2'd0;
  localparam logic [1:0] OP_INSERT  = 2'd1;
  localparam logic [1:0] OP_REMOVE  = 2'd2;
  localparam logic [1:0] OP_INVALID = 2'd3;

  // Result status codes
  localparam logic [2:0] STATUS_FOUND     = 3'd0;
  localparam logic [2:0] STATUS_ABSENT    = 3'd1;
  localparam logic [2:0] STATUS_INSERTED  = 3'd2;
  localparam logic [2:0] STATUS_DUPLICATE = 3'd3;
  localparam logic [2:0] STATUS_FULL      = 3'd4;
  localparam logic [2:0] STATUS_REMOVED   = 3'd5;
  localparam logic [2:0] STATUS_INVALID   = 3'd6;

  // Hash multiplier after reset
  localparam logic [63:0] MULT_RESET = 64'h9E37_79B9_7F4A_7C15;

endpackage

/* design/rhhs_hash.sv */
// Two-stage multiply-shift hash giving the home slot of a key.
module rhhs_hash #(
  parameter int TB = 10
) (
  input  logic          clk,
  input  logic [63:0]   mult,
  input  logic [30:0]   key,
  output logic [TB-1:0] home
);
  logic [62:0] p_lo;
  logic [31:0] p_hi;
  logic [63:0] sum;

  // Stage 1: two partial products, upper one only needs its low half
  always_ff @(posedge clk) begin
    p_lo <= 63'(64'(mult[31:0]) * 64'(key));
    p_hi <= 32'(mult[63:32] * 32'(key));
  end

  // Stage 2: combine modulo 2^64 and take the top bits
  assign sum = 64'(p_lo) + {p_hi, 32'd0};

  always_ff @(posedge clk) begin
    home <= sum[63 -: TB];
  end
endmodule

/* design/rhhs_fifo.sv */
// Two-entry queue between the front and back parts.
module rhhs_fifo #(
  parameter int W = 43
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic         valid,
  output logic [W-1:0] rdata
);
  logic [W-1:0] data [2];
  logic         wptr;
  logic         rptr;
  logic [1:0]   fill;

  assign full  = fill[1];
  assign valid = (fill != 2'd0);
  assign rdata = data[rptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      data[wptr] <= wdata;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop)  rptr <= ~rptr;
      fill <= fill + 2'(push) - 2'(pop);
    end
  end
endmodule

/* design/rhhs_front.sv */
// Front part: takes requests, classifies them and hashes the key.
module rhhs_front #(
  parameter int TB = 10
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [63:0]      mult,
  input  logic             clearing,
  input  logic             in_valid,
  output logic             in_stall,
  input  rhhs_pkg::req_t   in_data,
  output logic             q_push,
  output logic [TB+32:0]   q_wdata,
  input  logic             q_full
);
  import rhhs_pkg::*;

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_H1   = 2'd1;
  localparam logic [1:0] F_H2   = 2'd2;
  localparam logic [1:0] F_PUSH = 2'd3;

  logic [1:0]    state;
  logic [1:0]    op;
  logic [30:0]   key;
  logic [TB-1:0] home;
  logic          accept;

  assign in_stall = clearing || (state != F_IDLE);
  assign accept   = in_valid && !in_stall;
  assign q_push   = (state == F_PUSH) && !q_full;
  assign q_wdata  = {op, key, home};

  rhhs_hash #(.TB(TB)) u_hash (
    .clk  (clk),
    .mult (mult),
    .key  (key),
    .home (home)
  );

  // Request capture and classification
  always_ff @(posedge clk) begin
    if (accept) begin
      key <= in_data.lookup_key;
      if (in_data.lookup_key == 31'd0) begin
        op <= OP_INVALID;
      end else begin
        case (in_data.req_type)
          REQ_INSERT: op <= OP_INSERT;
          REQ_REMOVE: op <= OP_REMOVE;
          default:    op <= OP_LOOKUP;
        endcase
      end
    end
  end

  // Sequencer: wait out the hash, then hand over
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: if (accept) state <= F_H1;
        F_H1:   state <= F_H2;
        F_H2:   state <= F_PUSH;
        F_PUSH: if (!q_full) state <= F_IDLE;
        default: state <= F_IDLE;
      endcase
    end
  end
endmodule

/* design/rhhs_back.sv */
// Back part: slot store, probe sequencer and result register.
module rhhs_back #(
  parameter int TB = 10
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [63:0]      mult,
  output logic             clearing,
  input  logic             q_valid,
  input  logic [TB+32:0]   q_rdata,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output rhhs_pkg::res_t   out_data
);
  import rhhs_pkg::*;

  localparam int SLOTS = 1 << TB;

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_RD   = 3'd2;
  localparam logic [2:0] ST_H0   = 3'd3;
  localparam logic [2:0] ST_H1   = 3'd4;
  localparam logic [2:0] ST_DEC  = 3'd5;
  localparam logic [2:0] ST_OUT  = 3'd6;

  localparam logic [1:0] PH_FIND  = 2'd0;
  localparam logic [1:0] PH_INS   = 2'd1;
  localparam logic [1:0] PH_SHIFT = 2'd2;

  // Slot store
  logic [30:0]   mem [SLOTS];
  logic [30:0]   rdata;
  logic          we;
  logic [TB-1:0] waddr;
  logic [30:0]   wdata;

  logic [2:0]    state;
  logic [1:0]    phase;
  logic [1:0]    op;
  logic [30:0]   key;
  logic [TB-1:0] home;
  logic [TB-1:0] idx;
  logic [TB-1:0] hole;
  logic [TB:0]   d;
  logic [30:0]   carry;
  logic          placed;
  logic [TB:0]   dist_res;
  logic [TB:0]   count;
  logic [TB:0]   longest;
  logic [TB-1:0] clr_idx;
  logic [30:0]   resident;
  res_t          res;

  logic [TB-1:0] home_r;
  logic [TB-1:0] rdist;
  logic [TB:0]   rd_ext;
  logic [TB:0]   lg_new;
  logic          hit;
  logic          miss;
  logic          r_empty;

  assign clearing  = (state == ST_CLR);
  assign out_valid = (state == ST_OUT);
  assign out_data  = res;
  assign q_pop     = (state == ST_IDLE) && q_valid;

  rhhs_hash #(.TB(TB)) u_hash (
    .clk  (clk),
    .mult (mult),
    .key  (rdata),
    .home (home_r)
  );

  // Resident's distance from its home and probe outcome
  assign r_empty = (resident == 31'd0);
  assign rdist   = idx - home_r;
  assign rd_ext  = {1'b0, rdist};
  assign lg_new  = (d > longest) ? d : longest;
  assign hit     = (resident == key);
  assign miss    = !hit && (r_empty || (rd_ext < d) || (d == (TB+1)'(SLOTS - 1)));

  // Store write selection
  always_comb begin
    we    = 1'b0;
    waddr = idx;
    wdata = carry;
    if (state == ST_CLR) begin
      we    = 1'b1;
      waddr = clr_idx;
      wdata = '0;
    end else if (state == ST_DEC) begin
      case (phase)
        PH_INS: we = r_empty || (rd_ext < d);
        PH_SHIFT: begin
          we    = 1'b1;
          waddr = hole;
          wdata = (r_empty || rdist == '0) ? '0 : resident;
        end
        default: we = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[idx];
  end

  // Probe sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLR;
      clr_idx <= '0;
      count   <= '0;
      longest <= '0;
    end else begin
      unique case (state)
        ST_CLR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == '1) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (q_valid) begin
            {op, key, home} <= q_rdata;
            idx   <= q_rdata[TB-1:0];
            d     <= '0;
            phase <= PH_FIND;
            if (q_rdata[TB+32 -: 2] == OP_INVALID) begin
              res   <= '{STATUS_INVALID, 10'd0, 11'(count), 10'(longest)};
              state <= ST_OUT;
            end else begin
              state <= ST_RD;
            end
          end
        end
        ST_RD: state <= ST_H0;
        ST_H0: begin
          resident <= rdata;
          state    <= ST_H1;
        end
        ST_H1: state <= ST_DEC;
        ST_DEC: begin
          case (phase)
            PH_FIND: begin
              if (hit) begin
                case (op)
                  OP_INSERT: begin
                    res   <= '{STATUS_DUPLICATE, 10'(d), 11'(count), 10'(longest)};
                    state <= ST_OUT;
                  end
                  OP_REMOVE: begin
                    count    <= count - 1'b1;
                    dist_res <= d;
                    hole     <= idx;
                    idx      <= idx + 1'b1;
                    phase    <= PH_SHIFT;
                    state    <= ST_RD;
                  end
                  default: begin
                    res   <= '{STATUS_FOUND, 10'(d), 11'(count), 10'(longest)};
                    state <= ST_OUT;
                  end
                endcase
              end else if (miss) begin
                if (op == OP_INSERT && count != (TB+1)'(SLOTS)) begin
                  phase  <= PH_INS;
                  idx    <= home;
                  d      <= '0;
                  carry  <= key;
                  placed <= 1'b0;
                  state  <= ST_RD;
                end else begin
                  res <= '{(op == OP_INSERT) ? STATUS_FULL : STATUS_ABSENT, 10'd0,
                           11'(count), 10'(longest)};
                  state <= ST_OUT;
                end
              end else begin
                d     <= d + 1'b1;
                idx   <= idx + 1'b1;
                state <= ST_RD;
              end
            end
            PH_INS: begin
              if (r_empty) begin
                count   <= count + 1'b1;
                longest <= lg_new;
                res     <= '{STATUS_INSERTED, placed ? 10'(dist_res) : 10'(d),
                             11'(count + 1'b1), 10'(lg_new)};
                state   <= ST_OUT;
              end else begin
                if (rd_ext < d) begin
                  carry   <= resident;
                  longest <= lg_new;
                  if (!placed) begin
                    dist_res <= d;
                    placed   <= 1'b1;
                  end
                  d <= rd_ext + 1'b1;
                end else begin
                  d <= d + 1'b1;
                end
                idx   <= idx + 1'b1;
                state <= ST_RD;
              end
            end
            default: begin
              // backward shift: stop at an empty slot or a resident at home
              if (r_empty || rdist == '0) begin
                res   <= '{STATUS_REMOVED, 10'(dist_res), 11'(count), 10'(longest)};
                state <= ST_OUT;
              end else begin
                hole  <= idx;
                idx   <= idx + 1'b1;
                state <= ST_RD;
              end
            end
          endcase
        end
        ST_OUT: if (!out_stall) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (TB+1)'(SLOTS))
    else $error("element count above slot count");

  a_no_pop_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLR) |-> !q_pop)
    else $error("request taken during clearing pass");

  a_ins_key: assert property (@(posedge clk) disable iff (rst)
    (we && state == ST_DEC && phase == PH_INS) |-> (wdata != 31'd0))
    else $error("insert writes an empty key");
endmodule

/* design/robin_hood_hash_set_top.sv */
// Top level of the Robin Hood hash set with its hash multiplier register.
//
// Set of nonzero 31-bit keys in 2^TABLE_BITS slots, linear probing with Robin
// Hood displacement and backward-shift removal. After reset the slot store is
// cleared one slot a cycle, during which in_stall is high (configuration writes
// are taken). A request passes through the front (capture, two hash stages,
// hand-over) and then, in the back, a start step and for each probed slot a
// store read, two hash stages on the resident and a decide step, then the
// result; an insert of a new key probes once to search and again to place, a
// remove probes to find and then to shift.
// The single store port and the resident hash set the per-slot cost. The next
// request is taken while an earlier one is still in the back.
module robin_hood_hash_set_top #(
  parameter int TABLE_BITS = 10
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  rhhs_pkg::req_t  in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output rhhs_pkg::res_t  out_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [63:0]     cfg_data
);
  import rhhs_pkg::*;

  localparam int QW = TABLE_BITS + 33;

  logic [63:0]   mult;
  logic          clearing;
  logic          q_push;
  logic          q_full;
  logic          q_pop;
  logic          q_valid;
  logic [QW-1:0] q_wdata;
  logic [QW-1:0] q_rdata;

  assign cfg_ready = 1'b1;

  // Hash multiplier register, bit zero held at one
  always_ff @(posedge clk) begin
    if (rst) begin
      mult <= MULT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      mult <= cfg_data | 64'd1;
    end
  end

  rhhs_front #(.TB(TABLE_BITS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .mult     (mult),
    .clearing (clearing),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_push   (q_push),
    .q_wdata  (q_wdata),
    .q_full   (q_full)
  );

  rhhs_fifo #(.W(QW)) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_rdata)
  );

  rhhs_back #(.TB(TABLE_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .mult      (mult),
    .clearing  (clearing),
    .q_valid   (q_valid),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );
endmodule

/* sim/tb.sv */
// Self-checking testbench of the Robin Hood hash set with its own hash set predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rhhs_pkg::*;

  localparam int TB_BITS = 10;
  localparam int SLOTS = 1 << TB_BITS;
  localparam int MAX_CYCLES = 6000000;
  localparam int PHASE_ITEMS = 75;
  localparam logic [1:0] REQ_SPARE = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  req_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  res_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [63:0] cfg_data = '0;

  robin_hood_hash_set_top #(.TABLE_BITS(TB_BITS)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Predictor state
  logic [30:0] slot_key [SLOTS];
  int unsigned key_count;
  int unsigned longest;
  logic [63:0] mult;

  res_t pending_results[$];
  int errors = 0;
  int cycles = 0;
  int sent = 0;
  int results_seen = 0;
  int full_seen = 0;
  int stall_left = 0;
  int stall_mark = 0;
  bit calm = 1'b0;
  logic [30:0] key_pool [48];

  function automatic logic [9:0] home_slot(logic [30:0] k);
    logic [63:0] p;
    p = mult * {33'd0, k};
    return p[63 -: TB_BITS];
  endfunction

  function automatic logic [9:0] dist_of(logic [9:0] s, logic [30:0] k);
    return s - home_slot(k);
  endfunction

  // Search with the Robin Hood early exit
  function automatic bit locate(logic [30:0] k, output logic [9:0] s, output logic [9:0] d);
    logic [9:0] h;
    logic [9:0] p;
    h = home_slot(k);
    s = '0;
    d = '0;
    for (int i = 0; i < SLOTS; i++) begin
      p = h + 10'(i);
      if (slot_key[p] == '0) return 1'b0;
      if (slot_key[p] == k) begin
        s = p;
        d = 10'(i);
        return 1'b1;
      end
      if (int'(dist_of(p, slot_key[p])) < i) return 1'b0;
    end
    return 1'b0;
  endfunction

  // Applies one request to the predicted set and gives its result
  function automatic res_t hash_set_apply(req_t r);
    res_t o;
    logic [9:0] s, d, idx, nxt, rd;
    logic [30:0] carry, resident;
    int cur;
    bit placed;
    o = '0;
    d = '0;
    if (r.lookup_key == '0) begin
      o.status = STATUS_INVALID;
    end else if (r.req_type == REQ_INSERT) begin
      if (locate(r.lookup_key, s, d)) begin
        o.status = STATUS_DUPLICATE;
      end else if (key_count >= SLOTS) begin
        o.status = STATUS_FULL;
        d = '0;
      end else begin
        carry = r.lookup_key;
        cur = 0;
        idx = home_slot(r.lookup_key);
        placed = 1'b0;
        d = '0;
        for (int step = 0; step < SLOTS; step++) begin
          resident = slot_key[idx];
          if (resident == '0) begin
            slot_key[idx] = carry;
            key_count++;
            if (cur > longest) longest = cur;
            if (!placed) d = 10'(cur);
            break;
          end
          rd = dist_of(idx, resident);
          if (int'(rd) < cur) begin
            slot_key[idx] = carry;
            carry = resident;
            if (cur > longest) longest = cur;
            if (!placed) begin
              d = 10'(cur);
              placed = 1'b1;
            end
            cur = rd;
          end
          cur++;
          idx = idx + 10'd1;
        end
        o.status = STATUS_INSERTED;
      end
    end else if (r.req_type == REQ_REMOVE) begin
      if (locate(r.lookup_key, s, d)) begin
        // backward shift until an empty slot or a resident at home
        idx = s;
        nxt = s + 10'd1;
        slot_key[idx] = '0;
        key_count--;
        while (slot_key[nxt] != '0 && dist_of(nxt, slot_key[nxt]) != '0) begin
          slot_key[idx] = slot_key[nxt];
          slot_key[nxt] = '0;
          idx = nxt;
          nxt = nxt + 10'd1;
        end
        o.status = STATUS_REMOVED;
      end else begin
        o.status = STATUS_ABSENT;
        d = '0;
      end
    end else begin
      // lookup, the spare code included
      if (locate(r.lookup_key, s, d)) o.status = STATUS_FOUND;
      else begin
        o.status = STATUS_ABSENT;
        d = '0;
      end
    end
    o.probe_distance = d;
    o.element_count = 11'(key_count);
    o.max_probe_distance = 10'(longest);
    return o;
  endfunction

  // Sends one request; a typed result, where given, replaces the prediction
  task automatic send(req_t r, bit typed = 1'b0, res_t typed_res = '0);
    int gap;
    res_t p;
    gap = calm ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (in_stall);
    p = hash_set_apply(r);
    pending_results.push_back(typed ? typed_res : p);
    if (p.status == STATUS_FULL) full_seen++;
    sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic write_mult(logic [63:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    mult = v | 64'd1;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic req_t random_request();
    req_t r;
    int sel;
    sel = $urandom_range(0, 99);
    r.lookup_key = key_pool[$urandom_range(0, 47)];
    if (sel < 28) r.req_type = REQ_LOOKUP;
    else if (sel < 60) r.req_type = REQ_INSERT;
    else if (sel < 85) r.req_type = REQ_REMOVE;
    else begin
      // noise: spare code, zero key, extreme and wholly random keys
      r.req_type = 2'($urandom_range(0, 3));
      case ($urandom_range(0, 3))
        0: r.lookup_key = '0;
        1: r.lookup_key = '1;
        2: r.lookup_key = 31'($urandom);
        default: r.req_type = REQ_SPARE;
      endcase
    end
    return r;
  endfunction

  task automatic random_phase(logic [63:0] m, bit quiet);
    write_mult(m);
    calm = quiet;
    foreach (key_pool[i]) key_pool[i] = ($urandom_range(0, 3) == 0) ?
        31'($urandom_range(1, 64)) : 31'($urandom | 1);
    for (int i = 0; i < PHASE_ITEMS; i++) send(random_request());
    calm = 1'b0;
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // Result checking
  always @(posedge clk) begin
    res_t w;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
      end else begin
        w = pending_results.pop_front();
        check_field("status", w.status, out_data.status);
        check_field("probe_distance", w.probe_distance, out_data.probe_distance);
        check_field("element_count", w.element_count, out_data.element_count);
        check_field("max_probe_distance", w.max_probe_distance,
                    out_data.max_probe_distance);
      end
    end
  end

  // Receiver stalls, a fresh wait drawn after each result
  always @(negedge clk) begin
    if (results_seen != stall_mark) begin
      stall_mark = results_seen;
      stall_left = calm ? 0 : $urandom_range(0, 19);
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left = stall_left - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  typedef struct {
    logic [1:0]  op;
    logic [30:0] key;
    bit          typed;
    res_t        res;
  } row_t;

  row_t rows[$] = '{
    '{REQ_LOOKUP, 31'd5, 1'b1, '{STATUS_ABSENT, 10'd0, 11'd0, 10'd0}},
    '{REQ_REMOVE, 31'd5, 1'b1, '{STATUS_ABSENT, 10'd0, 11'd0, 10'd0}},
    '{REQ_INSERT, 31'd0, 1'b1, '{STATUS_INVALID, 10'd0, 11'd0, 10'd0}},
    '{REQ_LOOKUP, 31'd0, 1'b1, '{STATUS_INVALID, 10'd0, 11'd0, 10'd0}},
    '{REQ_REMOVE, 31'd0, 1'b1, '{STATUS_INVALID, 10'd0, 11'd0, 10'd0}},
    '{REQ_SPARE,  31'd0, 1'b1, '{STATUS_INVALID, 10'd0, 11'd0, 10'd0}},
    '{REQ_INSERT, 31'd5, 1'b1, '{STATUS_INSERTED, 10'd0, 11'd1, 10'd0}},
    '{REQ_INSERT, 31'd5, 1'b1, '{STATUS_DUPLICATE, 10'd0, 11'd1, 10'd0}},
    '{REQ_LOOKUP, 31'd5, 1'b1, '{STATUS_FOUND, 10'd0, 11'd1, 10'd0}},
    '{REQ_SPARE,  31'd5, 1'b1, '{STATUS_FOUND, 10'd0, 11'd1, 10'd0}},
    '{REQ_INSERT, 31'h7FFF_FFFF, 1'b0, '0},
    '{REQ_INSERT, 31'd1, 1'b0, '0},
    '{REQ_INSERT, 31'h4000_0000, 1'b0, '0},
    '{REQ_INSERT, 31'h2AAA_AAAA, 1'b0, '0},
    '{REQ_INSERT, 31'h5555_5555, 1'b0, '0},
    '{REQ_LOOKUP, 31'h7FFF_FFFF, 1'b0, '0},
    '{REQ_REMOVE, 31'd5, 1'b0, '0},
    '{REQ_LOOKUP, 31'd5, 1'b0, '0},
    '{REQ_REMOVE, 31'h7FFF_FFFF, 1'b0, '0},
    '{REQ_REMOVE, 31'h7FFF_FFFF, 1'b0, '0},
    '{REQ_SPARE,  31'd1, 1'b0, '0}
  };

  initial begin
    req_t r;
    int unsigned k;
    foreach (slot_key[i]) slot_key[i] = '0;
    key_count = 0;
    longest = 0;
    mult = MULT_RESET;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part with the reset multiplier
    foreach (rows[i]) begin
      r.req_type = rows[i].op;
      r.lookup_key = rows[i].key;
      send(r, rows[i].typed, rows[i].res);
    end

    // Random part under several multipliers, extremes among them
    random_phase(64'($urandom) << 32 | 64'($urandom), 1'b0);
    random_phase(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    random_phase(64'd0, 1'b0);
    random_phase(64'hFFFF_FFFF_0000_0000 | 64'($urandom), 1'b0);

    // Fill the table to the brim, then push past it
    write_mult(MULT_RESET);
    calm = 1'b1;
    k = 1;
    r.req_type = REQ_INSERT;
    while (key_count < SLOTS) begin
      r.lookup_key = 31'(k);
      send(r);
      k++;
    end
    calm = 1'b0;
    r.lookup_key = 31'(k);
    send(r);
    r.lookup_key = 31'd1;
    send(r);
    r.req_type = REQ_LOOKUP;
    send(r);
    r.req_type = REQ_REMOVE;
    for (int i = 1; i <= 20; i++) begin
      r.lookup_key = 31'(i);
      send(r);
    end

    // Let the last results come out
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    $display("Covered %0d requests, %0d results, %0d table-full rejections,",
             sent, results_seen, full_seen);
    $display("directed extremes plus random traffic under five multipliers.");
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
